[hw/rtl/smf_pkg.sv]
// ----------------------------------------------------------------------------
// smf_pkg
// Shared types and codes of the sliding median filter.
// ----------------------------------------------------------------------------
`default_nettype none

package smf_pkg;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_FILL = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SWEEP,
    ST_FILL,
    ST_OUT
  } smf_state_e;

  typedef enum logic [1:0] {
    MD_NORM,
    MD_RIGHT,
    MD_LEFT,
    MD_DONE
  } smf_mode_e;

endpackage

`default_nettype wire

[hw/rtl/smf_if.sv]
// ----------------------------------------------------------------------------
// smf_if
// Valid/ready channels of the sliding median filter: sample in, median out.
// ----------------------------------------------------------------------------
`default_nettype none

interface smf_in_if #(
  parameter int SAMPLE_BITS = 24
) ();
  logic                          valid;
  logic                          ready;
  logic                          opcode;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output opcode, output sample, input ready);
  modport sink (input valid, input opcode, input sample, output ready);
endinterface

interface smf_out_if #(
  parameter int SAMPLE_BITS = 24
) ();
  logic                        valid;
  logic                        ready;
  logic signed [SAMPLE_BITS:0] median_twice;

  modport source (output valid, output median_twice, input ready);
  modport sink (input valid, input median_twice, output ready);
endinterface

`default_nettype wire

[hw/rtl/sliding_median_filter_core.sv]
// ----------------------------------------------------------------------------
// sliding_median_filter_core
// Running median over the last WINDOW signed Q16.8 altitude samples.
//
// in_i carries an opcode and a sample. A push transfer drops the oldest
// sample, merges the new one into the sorted copy and returns twice the
// median on out_o (sum of the two middle ranks, or twice the middle rank).
// A fill transfer loads every slot with its sample and returns nothing.
// in_i.ready is high only while the sequencer is idle. A push runs one load
// step, one merge step per rank of the sorted memory, which has a single
// read and a single write port, and one output step. A new push is taken
// only after the previous one has left its output step. A fill writes one
// slot per cycle, and the next transfer is taken once the fill has written
// its last slot. The next transfer is
// taken while a result waits in the output register; a push that finishes
// while that register is still full holds until out_o is taken. Reset
// empties the output register and makes both stores read as zero until
// written; no clearing pass runs.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_median_filter_core
  import smf_pkg::*;
#(
  parameter int WINDOW      = 50,
  parameter int SAMPLE_BITS = 24
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  smf_in_if.sink     in_i,
  smf_out_if.source  out_o
);

  localparam int KW = $clog2(WINDOW);
  localparam int SW = SAMPLE_BITS;
  localparam int OW = SAMPLE_BITS + 1;
  localparam logic [KW-1:0] LAST   = KW'(WINDOW - 1);
  localparam logic [KW-1:0] MID_LO = KW'((WINDOW - 1) / 2);
  localparam logic [KW-1:0] MID_HI = KW'(WINDOW / 2);
  localparam bit ODD_WIN = (WINDOW % 2) != 0;

  smf_state_e state_q, state_d;
  smf_mode_e  mode_q, mode_d, mode_nxt;

  logic [KW-1:0]     k_q, k_d;
  logic [KW-1:0]     oldest_q, oldest_d;
  logic [WINDOW-1:0] ring_vld_q, ring_vld_d;
  logic              srt_init_q, srt_init_d;
  logic              out_vld_q, out_vld_d;

  logic signed [SW-1:0] fresh_q, fresh_d;
  logic signed [SW-1:0] gone_q, gone_d;
  logic signed [SW-1:0] prev_q, prev_d;
  logic signed [SW-1:0] cur_q, cur_d;
  logic signed [SW-1:0] lo_q, lo_d;
  logic signed [OW-1:0] med_q, med_d;
  logic signed [OW-1:0] out_med_q, out_med_d;

  logic signed [SW-1:0] ring_mem [WINDOW];
  logic signed [SW-1:0] srt_mem [WINDOW];
  logic signed [SW-1:0] ring_rd_q;
  logic                 ring_rd_vld_q;
  logic signed [SW-1:0] srt_rd_q;

  logic                 in_ready;
  logic                 ring_we;
  logic [KW-1:0]        ring_waddr;
  logic signed [SW-1:0] ring_wdata;
  logic                 srt_we;
  logic [KW-1:0]        srt_waddr;
  logic signed [SW-1:0] srt_wdata;
  logic [KW-1:0]        srt_raddr;

  logic signed [SW-1:0] nxt;
  logic                 nxt_ok;
  logic signed [SW-1:0] new_val;
  logic [KW:0]          ahead;
  logic                 ahead_ok;
  logic signed [SW-1:0] lo_sel;

  assign nxt      = srt_init_q ? srt_rd_q : '0;
  assign nxt_ok   = (k_q != LAST);
  assign ahead    = {1'b0, k_q} + (KW+1)'(2);
  assign ahead_ok = (ahead < (KW+1)'(WINDOW));
  assign lo_sel   = ODD_WIN ? new_val : lo_q;

  // Merge step: one rank of the new sorted window per cycle.
  always_comb begin
    new_val  = cur_q;
    mode_nxt = mode_q;
    case (mode_q)
      MD_NORM: begin
        if ((cur_q == gone_q) || (k_q == LAST)) begin
          if (nxt_ok && (nxt <= fresh_q)) begin
            new_val  = nxt;
            mode_nxt = MD_LEFT;
          end else begin
            new_val  = fresh_q;
            mode_nxt = MD_DONE;
          end
        end else if (fresh_q < cur_q) begin
          new_val  = fresh_q;
          mode_nxt = MD_RIGHT;
        end else begin
          new_val = cur_q;
        end
      end
      MD_RIGHT: begin
        if (prev_q == gone_q) begin
          new_val  = cur_q;
          mode_nxt = MD_DONE;
        end else begin
          new_val = prev_q;
        end
      end
      MD_LEFT: begin
        if (nxt_ok && (nxt <= fresh_q)) begin
          new_val = nxt;
        end else begin
          new_val  = fresh_q;
          mode_nxt = MD_DONE;
        end
      end
      MD_DONE: begin
        new_val = cur_q;
      end
      default: begin
        new_val  = cur_q;
        mode_nxt = MD_DONE;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          state_d = (in_i.opcode == OP_FILL) ? ST_FILL : ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_d = ST_SWEEP;
      end
      ST_SWEEP: begin
        if (k_q == LAST) begin
          state_d = ST_OUT;
        end
      end
      ST_FILL: begin
        if (k_q == LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (!out_vld_q || out_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    mode_d     = mode_q;
    k_d        = k_q;
    oldest_d   = oldest_q;
    ring_vld_d = ring_vld_q;
    srt_init_d = srt_init_q;
    fresh_d    = fresh_q;
    gone_d     = gone_q;
    prev_d     = prev_q;
    cur_d      = cur_q;
    lo_d       = lo_q;
    med_d      = med_q;
    out_med_d  = out_med_q;
    out_vld_d  = out_vld_q && !out_o.ready;
    in_ready   = 1'b0;
    ring_we    = 1'b0;
    ring_waddr = oldest_q;
    ring_wdata = fresh_q;
    srt_we     = 1'b0;
    srt_waddr  = k_q;
    srt_wdata  = new_val;
    srt_raddr  = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_i.valid) begin
          fresh_d = in_i.sample;
          k_d     = '0;
          mode_d  = MD_NORM;
        end
      end
      ST_LOAD: begin
        gone_d                = ring_rd_vld_q ? ring_rd_q : '0;
        cur_d                 = nxt;
        ring_we               = 1'b1;
        ring_vld_d[oldest_q]  = 1'b1;
        oldest_d              = (oldest_q == LAST) ? '0 : oldest_q + KW'(1);
        srt_raddr             = KW'(1);
      end
      ST_SWEEP: begin
        srt_we    = 1'b1;
        srt_raddr = ahead_ok ? ahead[KW-1:0] : '0;
        prev_d    = cur_q;
        cur_d     = nxt;
        mode_d    = mode_nxt;
        k_d       = (k_q == LAST) ? '0 : k_q + KW'(1);
        if (k_q == MID_LO) begin
          lo_d = new_val;
        end
        if (k_q == MID_HI) begin
          med_d = {lo_sel[SW-1], lo_sel} + {new_val[SW-1], new_val};
        end
        if (k_q == LAST) begin
          srt_init_d = 1'b1;
        end
      end
      ST_FILL: begin
        srt_we     = 1'b1;
        srt_wdata  = fresh_q;
        ring_we    = 1'b1;
        ring_waddr = k_q;
        k_d        = (k_q == LAST) ? '0 : k_q + KW'(1);
        if (k_q == LAST) begin
          ring_vld_d = '1;
          srt_init_d = 1'b1;
          oldest_d   = '0;
        end
      end
      ST_OUT: begin
        if (!out_vld_q || out_o.ready) begin
          out_vld_d = 1'b1;
          out_med_d = med_q;
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      mode_q     <= MD_NORM;
      k_q        <= '0;
      oldest_q   <= '0;
      ring_vld_q <= '0;
      srt_init_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      mode_q     <= mode_d;
      k_q        <= k_d;
      oldest_q   <= oldest_d;
      ring_vld_q <= ring_vld_d;
      srt_init_q <= srt_init_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fresh_q   <= fresh_d;
    gone_q    <= gone_d;
    prev_q    <= prev_d;
    cur_q     <= cur_d;
    lo_q      <= lo_d;
    med_q     <= med_d;
    out_med_q <= out_med_d;
  end

  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[ring_waddr] <= ring_wdata;
    end
    ring_rd_q     <= ring_mem[oldest_q];
    ring_rd_vld_q <= ring_vld_q[oldest_q];
  end

  always_ff @(posedge clk_i) begin
    if (srt_we) begin
      srt_mem[srt_waddr] <= srt_wdata;
    end
    srt_rd_q <= srt_mem[srt_raddr];
  end

  assign in_i.ready         = in_ready;
  assign out_o.valid        = out_vld_q;
  assign out_o.median_twice = out_med_q;

  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q) == ST_OUT)
    else $error("result raised outside the output step");

  a_rank_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP || state_q == ST_FILL) |-> k_q <= LAST)
    else $error("rank counter beyond window");

  a_oldest_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    oldest_q <= LAST)
    else $error("oldest slot beyond window");

  a_fill_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.opcode == OP_FILL) |=> state_q == ST_FILL)
    else $error("fill transfer did not start a fill sweep");

endmodule

`default_nettype wire
